// ----- rtl/ilir_pkg.sv -----
`default_nettype none
package ilir_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  position;
    logic [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic [1:0]  status;
    logic [4:0]  count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic pos_le_used;
    logic pos_lt_used;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/ilir_ctrl.sv -----
`default_nettype none
module ilir_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire  [1:0]          cmd,
  input  ilir_pkg::dp_stat_t  stat,
  output ilir_pkg::ctl_t      ctl,
  output logic                busy,
  output logic                done
);
  import ilir_pkg::*;

  logic   accept;

  assign accept = start && !busy;
  // every command finishes in the cycle it is taken
  assign busy   = 1'b0;

  always_comb begin
    ctl.load   = accept;
    ctl.op     = OP_NONE;
    ctl.status = ST_DONE;
    if (accept) begin
      unique case (cmd)
        CMD_APPEND: begin
          if (stat.full) ctl.status = ST_FULL;
          else           ctl.op     = OP_APPEND;
        end
        CMD_INSERT: begin
          // full check wins over the position check
          if (stat.full)              ctl.status = ST_FULL;
          else if (!stat.pos_le_used) ctl.status = ST_BAD_POS;
          else                        ctl.op     = OP_INSERT;
        end
        CMD_REMOVE: begin
          if (!stat.pos_lt_used) ctl.status = ST_BAD_POS;
          else                   ctl.op     = OP_REMOVE;
        end
        default: begin
          ctl.op = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
    end else begin
      done  <= accept;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ilir_datapath.sv -----
`default_nettype none
module ilir_datapath #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ilir_pkg::req_t      req,
  input  ilir_pkg::ctl_t      ctl,
  output ilir_pkg::dp_stat_t  stat,
  output ilir_pkg::rsp_t      rsp
);
  import ilir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int CE_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int RD_N  = (CAPACITY < 16) ? CAPACITY : 16;

  logic [WORD_BITS-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     used_next;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     used_ext;
  logic [63:0]          win64;
  logic [WORD_BITS-1:0] wstore;
  logic [WORD_BITS-1:0] taken;
  logic [63:0]          taken64;
  logic [CE_W-1:0]      cnt_ext;

  assign pos_ext  = CMP_W'(req.position);
  assign used_ext = CMP_W'(used);

  assign stat.full        = (used == CNT_W'(CAPACITY));
  assign stat.pos_le_used = (pos_ext <= used_ext);
  assign stat.pos_lt_used = (pos_ext <  used_ext);

  assign win64  = 64'(req.word_in);
  assign wstore = win64[WORD_BITS-1:0];

  // word at the requested position, for remove
  always_comb begin
    taken = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (req.position == 4'(i)) taken = entries[i];
    end
  end

  assign taken64 = 64'(taken);

  always_comb begin
    unique case (ctl.op)
      OP_APPEND, OP_INSERT: used_next = used + CNT_W'(1);
      OP_REMOVE:            used_next = used - CNT_W'(1);
      default:              used_next = used;
    endcase
  end

  assign cnt_ext = CE_W'(used_next);

  // one cell per entry, all shifting in the same cycle
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] up_word;
    logic [WORD_BITS-1:0] down_word;

    if (g == 0) begin : g_first
      assign up_word = entries[0];
    end else begin : g_mid
      assign up_word = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign down_word = '0;
    end else begin : g_inner
      assign down_word = entries[g+1];
    end

    always_ff @(posedge clk) begin
      unique case (ctl.op)
        OP_APPEND: begin
          if (used == CNT_W'(g)) entries[g] <= wstore;
        end
        OP_INSERT: begin
          if (CMP_W'(g) == pos_ext)     entries[g] <= wstore;
          else if (CMP_W'(g) > pos_ext) entries[g] <= up_word;
        end
        OP_REMOVE: begin
          if (CMP_W'(g) >= pos_ext) entries[g] <= down_word;
        end
        default: begin
          entries[g] <= entries[g];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rsp.word_out <= (ctl.op == OP_REMOVE) ? taken64[31:0] : 32'd0;
      rsp.status   <= ctl.status;
      rsp.count    <= cnt_ext[4:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/indexed_list_insert_remove_unit.sv -----
`default_nettype none
// channel   | ports                 | transfer
// ----------+-----------------------+---------------------------------
// command   | start, busy, request  | rising edge with start & !busy
// result    | done, result          | rising edge ending the done cycle
//
// a command is taken at an edge and its result shows for the following
// cycle. busy stays low, so a new command can be taken every cycle, also
// while the previous result is on the ports. reset (rst, synchronous)
// empties the list; entries need no clearing. the receiver cannot stall
// the result.
module indexed_list_insert_remove_unit #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  ilir_pkg::req_t  request,
  output logic            done,
  output ilir_pkg::rsp_t  result
);
  import ilir_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  ilir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (request.cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  ilir_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (request),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (result)
  );

endmodule
`default_nettype wire
